### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Types, codes and constants shared by the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  typedef enum logic [3:0] {
    PH_SYNC0   = 4'd0,
    PH_SYNC1   = 4'd1,
    PH_LEN     = 4'd2,
    PH_HW_LO   = 4'd3,
    PH_HW_HI   = 4'd4,
    PH_MID_LO  = 4'd5,
    PH_MID_HI  = 4'd6,
    PH_ROUTE   = 4'd7,
    PH_CMD     = 4'd8,
    PH_PAYLOAD = 4'd9,
    PH_HELD    = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_TAKEN    = 3'd1,
    EV_COMPLETE = 3'd2,
    EV_DROPPED  = 3'd3,
    EV_RELEASED = 3'd4
  } event_t;

  typedef enum logic {
    OP_LINE_BYTE = 1'b0,
    OP_RELEASE   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_OWN_ROUTE   = 2'd2
  } reg_idx_t;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd34;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd105;
  localparam logic [3:0] OWN_ROUTE_RST   = 4'd0;

  localparam logic [7:0] MIN_LENGTH   = 8'd6;
  localparam logic [9:0] PAYLOAD_BASE = 10'd9;
  localparam logic [8:0] LENGTH_EXTRA = 9'd3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] line_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  frame_length;
    logic [15:0] hardware_id;
    logic [15:0] message_number;
    logic [7:0]  route_byte;
    logic [7:0]  command_byte;
    logic        frame_held;
  } out_item_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [3:0] own_route;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  position;
    logic [8:0]  frame_end;
    logic [7:0]  length_hold;
    logic [15:0] hardware_hold;
    logic [15:0] message_hold;
    logic [7:0]  route_hold;
    logic [7:0]  command_hold;
    logic [7:0]  msg_low;
  } parse_state_t;

endpackage

### design/cfr_parse.sv
// ----------------------------------------------------------------------------
// cfr_parse
// One parser step: next parse state and result item for one input item.
// ----------------------------------------------------------------------------
module cfr_parse (
  input  cfr_pkg::cfg_t         cfg,
  input  cfr_pkg::parse_state_t st,
  input  cfr_pkg::in_item_t     item,
  output cfr_pkg::parse_state_t st_nxt,
  output cfr_pkg::out_item_t    result
);
  import cfr_pkg::*;

  parse_state_t nxt;
  event_t       ev;
  logic         pv;
  logic [7:0]   pb;
  logic [7:0]   pi;
  logic [7:0]   b;
  logic [7:0]   pos_inc;
  logic [9:0]   end_ext;

  assign b       = item.line_byte;
  assign pos_inc = st.position + 8'd1;
  assign end_ext = {1'b0, st.frame_end};

  always_comb begin
    nxt = st;
    ev  = EV_IGNORED;
    pv  = 1'b0;
    pb  = 8'd0;
    pi  = 8'd0;
    if (item.opcode == OP_RELEASE) begin
      if (st.phase == PH_HELD) begin
        nxt               = st;
        nxt.phase         = PH_SYNC0;
        nxt.position      = 8'd0;
        nxt.frame_end     = 9'd0;
        nxt.length_hold   = 8'd0;
        nxt.hardware_hold = 16'd0;
        nxt.route_hold    = 8'd0;
        nxt.command_hold  = 8'd0;
        nxt.msg_low       = 8'd0;
        ev                = EV_RELEASED;
      end
    end else begin
      case (st.phase)
        PH_SYNC0: begin
          if (b == cfg.sync_first) begin
            nxt.phase = PH_SYNC1;
            ev        = EV_TAKEN;
          end
        end
        PH_SYNC1: begin
          if (b == cfg.sync_second) begin
            nxt.phase = PH_LEN;
            ev        = EV_TAKEN;
          end else begin
            nxt.phase = PH_SYNC0;
            ev        = EV_DROPPED;
          end
        end
        PH_LEN: begin
          if (b >= MIN_LENGTH) begin
            nxt.length_hold = b;
            nxt.position    = 8'd0;
            nxt.frame_end   = {1'b0, b} + LENGTH_EXTRA;
            nxt.phase       = PH_HW_LO;
            ev              = EV_TAKEN;
          end else begin
            nxt.phase = PH_SYNC0;
            ev        = EV_DROPPED;
          end
        end
        PH_HW_LO: begin
          nxt.hardware_hold = {st.hardware_hold[15:8], b};
          nxt.phase         = PH_HW_HI;
          ev                = EV_TAKEN;
        end
        PH_HW_HI: begin
          nxt.hardware_hold = {b, st.hardware_hold[7:0]};
          nxt.phase         = PH_MID_LO;
          ev                = EV_TAKEN;
        end
        PH_MID_LO: begin
          nxt.msg_low = b;
          nxt.phase   = PH_MID_HI;
          ev          = EV_TAKEN;
        end
        PH_MID_HI: begin
          nxt.message_hold = {b, st.msg_low};
          nxt.phase        = PH_ROUTE;
          ev               = EV_TAKEN;
        end
        PH_ROUTE: begin
          if (b[7:4] == cfg.own_route) begin
            nxt.route_hold = b;
            nxt.phase      = PH_CMD;
            ev             = EV_TAKEN;
          end else begin
            nxt.phase = PH_SYNC0;
            ev        = EV_DROPPED;
          end
        end
        PH_CMD: begin
          nxt.command_hold = b;
          if (PAYLOAD_BASE < end_ext) begin
            nxt.phase = PH_PAYLOAD;
            ev        = EV_TAKEN;
          end else begin
            nxt.phase = PH_HELD;
            ev        = EV_COMPLETE;
          end
        end
        PH_PAYLOAD: begin
          if ({2'b00, st.position} + PAYLOAD_BASE < end_ext) begin
            pv           = 1'b1;
            pb           = b;
            pi           = st.position;
            nxt.position = pos_inc;
          end
          if ({2'b00, nxt.position} + PAYLOAD_BASE >= end_ext) begin
            nxt.phase = PH_HELD;
            ev        = EV_COMPLETE;
          end else begin
            ev = EV_TAKEN;
          end
        end
        PH_HELD: begin
          ev = EV_IGNORED;
        end
        default: begin
          nxt.phase = PH_SYNC0;
        end
      endcase
      // Drop and unknown phases fall back to hunting with holds cleared, except the message number.
      if (nxt.phase == PH_SYNC0 && st.phase != PH_SYNC0) begin
        nxt.position      = 8'd0;
        nxt.frame_end     = 9'd0;
        nxt.length_hold   = 8'd0;
        nxt.hardware_hold = 16'd0;
        nxt.route_hold    = 8'd0;
        nxt.command_hold  = 8'd0;
        nxt.msg_low       = 8'd0;
      end
    end
  end

  assign st_nxt = nxt;

  always_comb begin
    result.event_res      = ev;
    result.payload_valid  = pv;
    result.payload_byte   = pb;
    result.payload_index  = pi;
    result.frame_length   = nxt.length_hold;
    result.hardware_id    = nxt.hardware_hold;
    result.message_number = nxt.message_hold;
    result.route_byte     = nxt.route_hold;
    result.command_byte   = nxt.command_hold;
    result.frame_held     = (nxt.phase == PH_HELD);
  end

endmodule

### design/command_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// command_frame_receiver_core
// Byte-serial command frame parser with APB register port and streamed payload.
// ----------------------------------------------------------------------------
// Path: an input transfer is captured in the input register, then passes the single
//   parser step between the two registers into the result register.
// Throughput: 1 byte per cycle while results drain; the single parser step sets it.
// Reset (rst_n low, synchronous): parser hunts the first sync byte, holds and
//   positions clear, message id clears, registers return to 34 / 105 / 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module command_frame_receiver_core (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  cfr_pkg::in_item_t   in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output cfr_pkg::out_item_t  out_data,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cfr_pkg::*;

  // Configuration registers.
  cfg_t         cfg_r;
  logic         cfg_wr;
  reg_idx_t     cfg_idx;

  // Input register stage.
  logic         s1_valid_r;
  in_item_t     s1_item_r;

  // Parser state and result register.
  parse_state_t st_r;
  parse_state_t st_nxt;
  out_item_t    res_nxt;
  out_item_t    res_r;
  logic         res_valid_r;

  logic         res_free;
  logic         s1_advance;

  // ---------------------------------------------------------------------------
  // Register port: zero wait state, write on the access phase.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= SYNC_FIRST_RST;
      cfg_r.sync_second <= SYNC_SECOND_RST;
      cfg_r.own_route   <= OWN_ROUTE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SYNC_FIRST:  cfg_r.sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: cfg_r.sync_second <= pwdata[7:0];
        REG_OWN_ROUTE:   cfg_r.own_route   <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register, zero-extended; unmapped reads return 0.
  always_comb begin
    case (cfg_idx)
      REG_SYNC_FIRST:  prdata = {24'd0, cfg_r.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg_r.sync_second};
      REG_OWN_ROUTE:   prdata = {28'd0, cfg_r.own_route};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: the result register is free when empty or being drained.
  // The input register advances into it whenever it is free, so a new
  // transfer can land every cycle while the result side keeps up.
  // ---------------------------------------------------------------------------
  assign res_free   = ~res_valid_r | out_ready;
  assign s1_advance = s1_valid_r & res_free;
  assign in_ready   = ~s1_valid_r | res_free;

  // Capture the incoming transfer; hold it while the result side stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser step: one byte or release per cycle while the result register is free.
  // ---------------------------------------------------------------------------
  cfr_parse u_parse (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .result (res_nxt)
  );

  // Advance the parse state only together with loading its result, so the
  // state always matches the last result produced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= PH_SYNC0;
      st_r.position      <= 8'd0;
      st_r.frame_end     <= 9'd0;
      st_r.length_hold   <= 8'd0;
      st_r.hardware_hold <= 16'd0;
      st_r.message_hold  <= 16'd0;
      st_r.route_hold    <= 8'd0;
      st_r.command_hold  <= 8'd0;
      st_r.msg_low       <= 8'd0;
    end else if (s1_advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register: load on advance, drop valid once the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_free) begin
      res_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A payload byte is only reported as taken or completing the frame.
  `ASSERT_IMPLIES(a_payload_event, clk, rst_n, res_valid_r && res_r.payload_valid,
                  (res_r.event_res == EV_TAKEN) || (res_r.event_res == EV_COMPLETE))
  // The held flag in a pending result tracks the parser's current phase.
  `ASSERT_IMPLIES(a_held_matches, clk, rst_n, res_valid_r,
                  res_r.frame_held == (st_r.phase == PH_HELD))
  // While streaming payload, the position offset by the payload base stays below the frame end.
  `ASSERT_IMPLIES(a_payload_bound, clk, rst_n, st_r.phase == PH_PAYLOAD,
                  ({2'b00, st_r.position} + PAYLOAD_BASE) < {1'b0, st_r.frame_end})
  // A stalled input register stays valid in the next cycle.
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, s1_valid_r && !res_free, s1_valid_r)

endmodule
